/* rtl/lfw_pkg.sv */
`timescale 1ns / 1ps

package lfw_pkg;

  // Screen size defaults and the widest clipped dimension the design supports
  localparam int unsigned SCREEN_WIDTH_DEF  = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;
  localparam int unsigned SCREEN_DIM_MAX    = 4096;
  localparam int unsigned DIM_W             = $clog2(SCREEN_DIM_MAX + 1);
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  localparam int unsigned RUN_LEN_W = 25;

  // Request codes
  localparam logic [2:0] CMD_FILL      = 3'd0;
  localparam logic [2:0] CMD_PIXEL     = 3'd1;
  localparam logic [2:0] CMD_IMG_WIN   = 3'd2;
  localparam logic [2:0] CMD_IMG_PIXEL = 3'd3;
  localparam logic [2:0] CMD_RAW_CMD   = 3'd4;
  localparam logic [2:0] CMD_RAW_DATA  = 3'd5;

  // Panel opcodes
  localparam logic [7:0] OP_CASET = 8'h2A;
  localparam logic [7:0] OP_RASET = 8'h2B;
  localparam logic [7:0] OP_RAMWR = 8'h2C;

  typedef enum logic [1:0] {
    KIND_WINDOW,
    KIND_RUN,
    KIND_BYTE
  } job_kind_e;

  // Sequencer steps of the back end, in bus order
  typedef enum logic [3:0] {
    STEP_CASET,
    STEP_XS_HI,
    STEP_XS_LO,
    STEP_XE_HI,
    STEP_XE_LO,
    STEP_RASET,
    STEP_YS_HI,
    STEP_YS_LO,
    STEP_YE_HI,
    STEP_YE_LO,
    STEP_RAMWR,
    STEP_RUN,
    STEP_RAW
  } step_e;

  typedef struct packed {
    job_kind_e        kind;
    logic             has_run;
    logic [15:0]      x_start;
    logic [15:0]      y_start;
    logic [15:0]      x_end;
    logic [15:0]      y_end;
    logic [DIM_W-1:0] run_w;
    logic [DIM_W-1:0] run_h;
    logic [15:0]      color;
    logic [7:0]       raw_byte;
    logic             raw_is_data;
  } job_t;

  typedef struct packed {
    logic                 is_data;
    logic [7:0]           bus_byte;
    logic                 is_pixel_run;
    logic [15:0]          run_color;
    logic [RUN_LEN_W-1:0] run_length;
    logic                 last;
  } res_t;

endpackage

/* rtl/lfw_if.sv */
`timescale 1ns / 1ps

interface lfw_req_if import lfw_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [15:0] color;
  logic [7:0]  raw_byte;

  modport source (
    output valid, cmd, x_pos, y_pos, rect_width, rect_height, color, raw_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_pos, y_pos, rect_width, rect_height, color, raw_byte,
    output ready
  );
endinterface

interface lfw_res_if import lfw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 is_data;
  logic [7:0]           bus_byte;
  logic                 is_pixel_run;
  logic [15:0]          run_color;
  logic [RUN_LEN_W-1:0] run_length;
  logic                 last;

  modport source (
    output valid, is_data, bus_byte, is_pixel_run, run_color, run_length, last,
    input  ready
  );
  modport sink (
    input  valid, is_data, bus_byte, is_pixel_run, run_color, run_length, last,
    output ready
  );
endinterface

/* rtl/lfw_front.sv */
`timescale 1ns / 1ps

module lfw_front import lfw_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  lfw_req_if.sink req_i,
  output logic    push_valid_o,
  input  logic    push_ready_i,
  output job_t    push_job_o
);

  localparam logic [16:0] SW     = 17'(SCREEN_WIDTH);
  localparam logic [16:0] SH     = 17'(SCREEN_HEIGHT);
  localparam logic [15:0] SW_END = 16'(SCREEN_WIDTH - 1);
  localparam logic [15:0] SH_END = 16'(SCREEN_HEIGHT - 1);

  logic        on_screen;
  logic [16:0] x_sum;
  logic [16:0] y_sum;
  logic        clip_x;
  logic        clip_y;
  logic [15:0] x_end_raw;
  logic [15:0] y_end_raw;
  logic [16:0] x_room;
  logic [16:0] y_room;
  logic        keep;
  job_t        job;

  assign on_screen = ({1'b0, req_i.x_pos} < SW) && ({1'b0, req_i.y_pos} < SH);
  assign x_sum     = {1'b0, req_i.x_pos} + {1'b0, req_i.rect_width};
  assign y_sum     = {1'b0, req_i.y_pos} + {1'b0, req_i.rect_height};
  assign clip_x    = x_sum > SW;
  assign clip_y    = y_sum > SH;
  assign x_end_raw = req_i.x_pos + req_i.rect_width - 16'd1;
  assign y_end_raw = req_i.y_pos + req_i.rect_height - 16'd1;
  assign x_room    = SW - {1'b0, req_i.x_pos};
  assign y_room    = SH - {1'b0, req_i.y_pos};

  always_comb begin
    job             = '0;
    job.kind        = KIND_WINDOW;
    job.x_start     = req_i.x_pos;
    job.y_start     = req_i.y_pos;
    job.color       = req_i.color;
    job.raw_byte    = req_i.raw_byte;
    keep            = 1'b0;
    unique case (req_i.cmd)
      CMD_FILL: begin
        // A clipped end lands on the last column or row
        keep        = on_screen;
        job.x_end   = clip_x ? SW_END : x_end_raw;
        job.y_end   = clip_y ? SH_END : y_end_raw;
        job.run_w   = clip_x ? x_room[DIM_W-1:0] : req_i.rect_width[DIM_W-1:0];
        job.run_h   = clip_y ? y_room[DIM_W-1:0] : req_i.rect_height[DIM_W-1:0];
        job.has_run = (req_i.rect_width != 16'd0) && (req_i.rect_height != 16'd0);
      end
      CMD_PIXEL: begin
        keep        = on_screen;
        job.x_end   = req_i.x_pos;
        job.y_end   = req_i.y_pos;
        job.run_w   = DIM_W'(1);
        job.run_h   = DIM_W'(1);
        job.has_run = 1'b1;
      end
      CMD_IMG_WIN: begin
        keep      = 1'b1;
        job.x_end = x_end_raw;
        job.y_end = y_end_raw;
      end
      CMD_IMG_PIXEL: begin
        keep        = 1'b1;
        job.kind    = KIND_RUN;
        job.has_run = 1'b1;
      end
      CMD_RAW_CMD: begin
        keep     = 1'b1;
        job.kind = KIND_BYTE;
      end
      CMD_RAW_DATA: begin
        keep            = 1'b1;
        job.kind        = KIND_BYTE;
        job.raw_is_data = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // Dropped requests are still taken, they just never reach the queue
  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid && keep;
  assign push_job_o   = job;

endmodule

/* rtl/lfw_queue.sv */
`timescale 1ns / 1ps

module lfw_queue import lfw_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* rtl/lfw_back.sv */
`timescale 1ns / 1ps

module lfw_back import lfw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  lfw_res_if.source res_o
);

  logic                 busy_q, busy_d;
  step_e                step_q, step_d;
  job_t                 cur_q, cur_d;
  logic [RUN_LEN_W-1:0] len_q;
  logic                 res_vld_q, res_vld_d;
  res_t                 res_q, res_d;
  res_t                 item;
  logic                 emit;
  logic                 final_step;
  logic                 load;
  logic [2*DIM_W-1:0]   area;

  assign emit       = busy_q && (!res_vld_q || res_o.ready);
  assign final_step = (cur_q.kind == KIND_BYTE) || (step_q == STEP_RUN) ||
                      ((step_q == STEP_RAMWR) && !cur_q.has_run);
  assign load       = job_valid_i && (!busy_q || (emit && final_step));
  assign job_pop_o  = load;
  assign area       = cur_q.run_w * cur_q.run_h;

  // Next state of the sequencer
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    cur_d  = cur_q;
    if (load) begin
      busy_d = 1'b1;
      cur_d  = job_i;
      unique case (job_i.kind)
        KIND_RUN:  step_d = STEP_RUN;
        KIND_BYTE: step_d = STEP_RAW;
        default:   step_d = STEP_CASET;
      endcase
    end else if (emit && final_step) begin
      busy_d = 1'b0;
    end else if (emit) begin
      step_d = step_e'(step_q + 4'd1);
    end
  end

  // Result for the current step
  always_comb begin
    item         = '0;
    item.is_data = 1'b1;
    item.last    = final_step;
    unique case (step_q)
      STEP_CASET: begin
        item.is_data  = 1'b0;
        item.bus_byte = OP_CASET;
      end
      STEP_XS_HI: item.bus_byte = cur_q.x_start[15:8];
      STEP_XS_LO: item.bus_byte = cur_q.x_start[7:0];
      STEP_XE_HI: item.bus_byte = cur_q.x_end[15:8];
      STEP_XE_LO: item.bus_byte = cur_q.x_end[7:0];
      STEP_RASET: begin
        item.is_data  = 1'b0;
        item.bus_byte = OP_RASET;
      end
      STEP_YS_HI: item.bus_byte = cur_q.y_start[15:8];
      STEP_YS_LO: item.bus_byte = cur_q.y_start[7:0];
      STEP_YE_HI: item.bus_byte = cur_q.y_end[15:8];
      STEP_YE_LO: item.bus_byte = cur_q.y_end[7:0];
      STEP_RAMWR: begin
        item.is_data  = 1'b0;
        item.bus_byte = OP_RAMWR;
      end
      STEP_RUN: begin
        item.is_pixel_run = 1'b1;
        item.run_color    = cur_q.color;
        item.run_length   = (cur_q.kind == KIND_RUN) ? RUN_LEN_W'(1) : len_q;
      end
      STEP_RAW: begin
        item.is_data  = cur_q.raw_is_data;
        item.bus_byte = cur_q.raw_byte;
      end
      default: item = '0;
    endcase
  end

  always_comb begin
    res_vld_d = res_vld_q;
    res_d     = res_q;
    if (emit) begin
      res_vld_d = 1'b1;
      res_d     = item;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= STEP_CASET;
      res_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      step_q    <= step_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Area settles long before the run step of a window job
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    len_q <= area[RUN_LEN_W-1:0];
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.is_data      = res_q.is_data;
  assign res_o.bus_byte     = res_q.bus_byte;
  assign res_o.is_pixel_run = res_q.is_pixel_run;
  assign res_o.run_color    = res_q.run_color;
  assign res_o.run_length   = res_q.run_length;
  assign res_o.last         = res_q.last;

  a_byte_job_raw_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cur_q.kind == KIND_BYTE) |-> step_q == STEP_RAW)
    else $error("byte job outside raw step");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.is_pixel_run |-> res_q.run_length != '0 && res_q.last)
    else $error("pixel run empty or not last");

  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o && busy_q |-> emit && final_step)
    else $error("job loaded over a running job");

endmodule

/* rtl/lcd_window_fill_writer.sv */
`timescale 1ns / 1ps

// Channel  Dir  Modport     Payload
// req_i    in   sink        cmd, x_pos, y_pos, rect_width, rect_height, color, raw_byte
// res_o    out  source      is_data, bus_byte, is_pixel_run, run_color, run_length, last
//
// One bus result leaves per cycle while the receiver is ready; the back-end step
// sequencer sets that rate. A fill with a nonempty run or a pixel request gives the
// window bytes and then the pixel run, an empty fill or an image window gives the window
// bytes only, and an image pixel or raw byte gives one result. Requests are taken into a
// small job queue, so the front keeps accepting while the back end works and while a
// finished result waits in the output register, until the queue fills.
// Off-screen fills and pixels and undefined codes are taken and produce nothing.
// Reset (rst_ni low, asynchronous) empties the queue, idles the sequencer and
// drops the output register; no clearing pass is needed.

module lcd_window_fill_writer import lfw_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfw_req_if.sink   req_i,
  lfw_res_if.source res_o
);

  // Front to queue
  logic push_valid;
  logic push_ready;
  job_t push_job;

  // Queue to back end
  logic job_valid;
  logic job_pop;
  job_t job;

  // Classify, clip and compute window ends for each request
  lfw_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Decouple front and back so either side can stall alone
  lfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .pop_job_o    (job)
  );

  // Step through window bytes, the pixel run or a raw byte, one result per cycle while the receiver is ready
  lfw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_o       (res_o)
  );

endmodule

/* test/lfw_bus_write_checker.sv */
`timescale 1ns / 1ps

module lfw_bus_write_checker import lfw_pkg::*; #(
  parameter int unsigned SCREEN_W = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_H = SCREEN_HEIGHT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  lfw_req_if   req_mon,
  lfw_res_if   res_mon,
  output int   mismatches_o,
  output int   pending_o
);

  localparam int unsigned PRINT_CAP = 60;

  res_t        bus_writes_due[$];
  int          mismatches = 0;
  int unsigned results_seen = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] bus write mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                              results_seen, name, got, want));
    end
  endtask

  task automatic push_byte(input logic is_data, input logic [7:0] b);
    res_t r;
    r              = '0;
    r.is_data      = is_data;
    r.bus_byte     = b;
    bus_writes_due.push_back(r);
  endtask

  task automatic push_run(input logic [15:0] color, input int unsigned len);
    res_t r;
    r              = '0;
    r.is_data      = 1'b1;
    r.is_pixel_run = 1'b1;
    r.run_color    = color;
    r.run_length   = RUN_LEN_W'(len);
    bus_writes_due.push_back(r);
  endtask

  task automatic push_window(input logic [15:0] x1, input logic [15:0] y1,
                             input logic [15:0] x2, input logic [15:0] y2);
    push_byte(1'b0, OP_CASET);
    push_byte(1'b1, x1[15:8]);
    push_byte(1'b1, x1[7:0]);
    push_byte(1'b1, x2[15:8]);
    push_byte(1'b1, x2[7:0]);
    push_byte(1'b0, OP_RASET);
    push_byte(1'b1, y1[15:8]);
    push_byte(1'b1, y1[7:0]);
    push_byte(1'b1, y2[15:8]);
    push_byte(1'b1, y2[7:0]);
    push_byte(1'b0, OP_RAMWR);
  endtask

  // Expand one request into the bus writes it must produce.
  task automatic predict_bus_writes(input logic [2:0] op,
                                    input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] w, input logic [15:0] h,
                                    input logic [15:0] color, input logic [7:0] raw);
    int unsigned cw;
    int unsigned ch;
    int unsigned before_cnt;
    res_t        tail;
    before_cnt = bus_writes_due.size();
    cw         = w;
    ch         = h;
    case (op)
      CMD_FILL: begin
        if (x < SCREEN_W && y < SCREEN_H) begin
          if (x + cw > SCREEN_W) cw = SCREEN_W - x;
          if (y + ch > SCREEN_H) ch = SCREEN_H - y;
          push_window(x, y, 16'(x + cw - 1), 16'(y + ch - 1));
          if (cw * ch != 0) push_run(color, cw * ch);
        end
      end
      CMD_PIXEL: begin
        if (x < SCREEN_W && y < SCREEN_H) begin
          push_window(x, y, x, y);
          push_run(color, 1);
        end
      end
      CMD_IMG_WIN:   push_window(x, y, 16'(x + cw - 1), 16'(y + ch - 1));
      CMD_IMG_PIXEL: push_run(color, 1);
      CMD_RAW_CMD:   push_byte(1'b0, raw);
      CMD_RAW_DATA:  push_byte(1'b1, raw);
      default: ;
    endcase
    if (bus_writes_due.size() > before_cnt) begin
      tail      = bus_writes_due.pop_back();
      tail.last = 1'b1;
      bus_writes_due.push_back(tail);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      // Compare first: a result leaving at this edge cannot come from a
      // request taken at the same edge.
      if (res_mon.valid && res_mon.ready) begin
        if (bus_writes_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                  results_seen));
        end else begin
          want = bus_writes_due.pop_front();
          check_field("is_data", res_mon.is_data, want.is_data);
          check_field("bus_byte", res_mon.bus_byte, want.bus_byte);
          check_field("is_pixel_run", res_mon.is_pixel_run, want.is_pixel_run);
          check_field("run_color", res_mon.run_color, want.run_color);
          check_field("run_length", res_mon.run_length, want.run_length);
          check_field("last", res_mon.last, want.last);
        end
        results_seen++;
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_bus_writes(req_mon.cmd, req_mon.x_pos, req_mon.y_pos,
                           req_mon.rect_width, req_mon.rect_height,
                           req_mon.color, req_mon.raw_byte);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= bus_writes_due.size();
  end

endmodule

/* test/tb_lcd_window_fill_writer.sv */
`timescale 1ns / 1ps

// Drive drawing requests into the display bus writer and let the checker
// beside it predict and compare every bus write. This module only makes
// stimulus, holds the cycle limit and gives the verdict.
module tb_lcd_window_fill_writer;
  import lfw_pkg::*;

  localparam int unsigned SCREEN_W        = SCREEN_WIDTH_DEF;
  localparam int unsigned SCREEN_H        = SCREEN_HEIGHT_DEF;
  localparam int unsigned REQUESTS_WANTED = 230;
  // Directed requests sent ahead of the random ones.
  localparam int unsigned DIRECTED_COUNT  = 23;
  // Slowest honest run: 12 writes per request, receiver stalling a third of
  // the time; the limit takes it many times over.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  // Queue of 2 plus a 12-write request plus the output register, padded.
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned IDLE_PCT        = 36;
  // Requests in this window go back to back with the receiver always ready.
  localparam int unsigned CALM_FIRST      = 90;
  localparam int unsigned CALM_LAST       = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        steady = 1'b0;
  int unsigned cycles = 0;
  int          mismatches;
  int          pending;

  lfw_req_if req_bus ();
  lfw_res_if res_bus ();

  lcd_window_fill_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  lfw_bus_write_checker #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_bus),
    .res_mon      (res_bus),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_lcd_window_fill_writer: errors");
      $finish;
    end
  end

  // Stall the result side at random, except inside the calm window.
  always @(negedge clk_i) begin
    res_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Offer one request and hold it until the writer takes it. Random gaps
  // go in front; valid stays high straight into the next request when no
  // gap is drawn, so it is never dropped and raised in one step.
  task automatic send_request(input logic [2:0] op,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] color, input logic [7:0] raw);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= op;
    req_bus.x_pos       <= x;
    req_bus.y_pos       <= y;
    req_bus.rect_width  <= w;
    req_bus.rect_height <= h;
    req_bus.color       <= color;
    req_bus.raw_byte    <= raw;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  // Pick a coordinate: mostly on screen so fills and pixels get past the
  // bounds check, sometimes anywhere in the 16-bit range.
  function automatic logic [15:0] pick_coord(input int unsigned limit);
    if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, limit - 1));
    return 16'($urandom);
  endfunction

  // Pick a size: small runs dominate, some span the screen, some are huge.
  function automatic logic [15:0] pick_size(input int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 16'($urandom_range(0, 16));
    if (roll < 75) return 16'($urandom_range(0, limit + 8));
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned random_sent;
    logic [2:0]  op;
    logic [15:0] x;
    logic [15:0] y;

    // Drive every input to a known value before the first edge.
    rst_ni              = 1'b0;
    res_bus.ready       = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.cmd         = CMD_FILL;
    req_bus.x_pos       = '0;
    req_bus.y_pos       = '0;
    req_bus.rect_width  = '0;
    req_bus.rect_height = '0;
    req_bus.color       = '0;
    req_bus.raw_byte    = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests: screen corners, clipping, empty fills with wrapped
    // window ends, off-screen origins, every request code, field extremes.
    send_request(CMD_FILL, 16'd0, 16'd0, 16'(SCREEN_W), 16'(SCREEN_H), 16'hFFFF, 8'h00);
    send_request(CMD_FILL, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 8'hFF);
    send_request(CMD_FILL, 16'(SCREEN_W - 1), 16'(SCREEN_H - 1), 16'hFFFF, 16'hFFFF,
                 16'hA5A5, 8'h00);
    send_request(CMD_FILL, 16'd10, 16'd20, 16'd5, 16'd0, 16'h1234, 8'h00);
    send_request(CMD_FILL, 16'd0, 16'd5, 16'd3, 16'hFFFF, 16'h5A5A, 8'h00);
    send_request(CMD_FILL, 16'(SCREEN_W), 16'd0, 16'd4, 16'd4, 16'hFFFF, 8'h00);
    send_request(CMD_FILL, 16'd0, 16'(SCREEN_H), 16'd4, 16'd4, 16'hFFFF, 8'h00);
    send_request(CMD_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(CMD_PIXEL, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00);
    send_request(CMD_PIXEL, 16'(SCREEN_W - 1), 16'(SCREEN_H - 1), 16'd0, 16'd0,
                 16'hFFFF, 8'h00);
    send_request(CMD_PIXEL, 16'(SCREEN_W), 16'd3, 16'd1, 16'd1, 16'hBEEF, 8'h00);
    send_request(CMD_PIXEL, 16'd3, 16'hFFFF, 16'd1, 16'd1, 16'hBEEF, 8'h00);
    send_request(CMD_IMG_WIN, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 8'h00);
    send_request(CMD_IMG_WIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(CMD_IMG_WIN, 16'd1000, 16'd2000, 16'd300, 16'd400, 16'h0000, 8'h00);
    send_request(CMD_IMG_PIXEL, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'h00);
    send_request(CMD_IMG_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 8'hFF);
    send_request(CMD_RAW_CMD, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 8'hFF);
    send_request(CMD_RAW_CMD, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 8'h00);
    send_request(CMD_RAW_DATA, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 8'h00);
    send_request(CMD_RAW_DATA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(3'd6, 16'd1, 16'd1, 16'd1, 16'd1, 16'h1111, 8'h11);
    send_request(3'd7, 16'd2, 16'd2, 16'd2, 16'd2, 16'h2222, 8'h22);

    // Random requests fill up the total; undefined codes and off-screen
    // fills or pixels are mixed in as noise.
    random_sent = 0;
    while (random_sent < REQUESTS_WANTED - DIRECTED_COUNT) begin
      steady = (random_sent >= CALM_FIRST) && (random_sent < CALM_LAST);
      if ($urandom_range(0, 99) < 92) op = 3'($urandom_range(0, 5));
      else op = 3'($urandom_range(6, 7));
      x = pick_coord(SCREEN_W);
      y = pick_coord(SCREEN_H);
      send_request(op, x, y, pick_size(SCREEN_W), pick_size(SCREEN_H),
                   16'($urandom), 8'($urandom));
      random_sent++;
    end
    steady = 1'b0;
    req_bus.valid <= 1'b0;

    // Drain: wait for every predicted write, then let stray writes surface.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("tb_lcd_window_fill_writer: clean");
    end else begin
      $display("tb_lcd_window_fill_writer: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lfw_pkg.sv
rtl/lfw_if.sv
rtl/lfw_front.sv
rtl/lfw_queue.sv
rtl/lfw_back.sv
rtl/lcd_window_fill_writer.sv
test/lfw_bus_write_checker.sv
test/tb_lcd_window_fill_writer.sv
